// File: rtl/hdrtm_pkg.sv
`timescale 1ns / 1ps
// hdrtm_pkg: shared types and constants of the HDR tone mapper.
// No dependencies; imported by the top level, curve prep and divider.
package hdrtm_pkg;

    localparam int CH_W     = 24;
    localparam int OUT_W    = 16;
    localparam int ALPHA_W  = 16;
    localparam int DIV_W    = 62;
    localparam int DIV_STEPS = 16;
    // four prep stages, one compare stage, one stage per quotient bit
    localparam int PIPE_DEPTH = 4 + 1 + DIV_STEPS;

    localparam logic [OUT_W-1:0] OUT_MAX  = 16'hFFFF;
    localparam logic [CH_W-1:0]  CH_MAX   = 24'hFFFFFF;
    localparam logic [12:0]      UC_NUM_K = 13'd6119;
    localparam logic [16:0]      UC_DEN_K = 17'd66556;

    typedef enum logic [2:0] {
        CURVE_CLAMP        = 3'd0,
        CURVE_REINHARD     = 3'd1,
        CURVE_EXT_REINHARD = 3'd2,
        CURVE_ACES         = 3'd3,
        CURVE_UNCHARTED2   = 3'd4
    } curve_mode_t;

    localparam logic [1:0] REG_CURVE_MODE = 2'd0;
    localparam logic [1:0] REG_EXPOSURE   = 2'd1;

    // ratio handed from curve setup to the divider
    typedef struct packed {
        logic             bypass;
        logic [OUT_W-1:0] bval;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } prep_word_t;

    // one stage of the restoring divider
    typedef struct packed {
        logic             bypass;
        logic [OUT_W-1:0] q;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] den;
    } div_word_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] alpha;
        logic               last;
    } side_word_t;

endpackage

// File: rtl/hdr_tone_mapper_unit.sv
`timescale 1ns / 1ps
// hdr_tone_mapper_unit: top level of the HDR tone mapper.
// Uses hdrtm_pkg, hdrtm_curve_prep and hdrtm_divider.
//
// Usage:
//   Input channel in_valid/in_ready carries one pixel word: red_in, green_in,
//   blue_in (unsigned 8.16 by default), alpha_in and last_in.
//   Output channel out_valid/out_ready carries the mapped word: red_out,
//   green_out, blue_out (unsigned 0.16), alpha_out and last_out.
//   cfg_we/cfg_index/cfg_data write curve_mode (index 0) and exposure_gain
//   (index 1); write only while no pixel is in flight.
// Pipeline: 4 setup stages for exposure multiply, curve factors and their
//   products, 1 compare stage, 16 stages of the restoring divider, one
//   quotient bit each.
// Throughput: one word per cycle while out_ready keeps up; every stage moves on the same enable.
// Stall: when out_ready is low with a word waiting, the whole pipeline and
//   in_ready freeze together; nothing is dropped or repeated. Bubbles inside
//   the pipeline are not squeezed out, but in_ready is high whenever the
//   output stage is empty or being taken.
// Reset: valid bits clear, curve_mode returns to clamp and exposure_gain
//   to 1.0.
module hdr_tone_mapper_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [23:0] red_in,
    input  logic [23:0] green_in,
    input  logic [23:0] blue_in,
    input  logic [15:0] alpha_in,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] red_out,
    output logic [15:0] green_out,
    output logic [15:0] blue_out,
    output logic [15:0] alpha_out,
    output logic        last_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    import hdrtm_pkg::*;

    curve_mode_t mode_reg;
    logic [23:0] gain_reg;
    logic        vld_reg [0:PIPE_DEPTH-1];
    side_word_t  side_reg [0:PIPE_DEPTH-1];
    logic        en;
    prep_word_t  prep_r, prep_g, prep_b;

    // config registers; modes past the last curve map to Uncharted 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= CURVE_CLAMP;
            gain_reg <= 24'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CURVE_MODE:
                begin
                    mode_reg <= (cfg_data[2:0] > 3'(CURVE_UNCHARTED2)) ?
                                CURVE_UNCHARTED2 : curve_mode_t'(cfg_data[2:0]);
                end
                REG_EXPOSURE:
                begin
                    gain_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // single pipeline enable: advance unless a finished word is held
    assign en       = out_ready | ~vld_reg[PIPE_DEPTH-1];
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // alpha and last ride alongside the color channels
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].alpha <= alpha_in;
            side_reg[0].last  <= last_in;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    hdrtm_curve_prep #(.FRAC_BITS(FRAC_BITS)) u_prep_r (
        .clk(clk), .en(en), .curve_mode(mode_reg), .exposure_gain(gain_reg),
        .chan(red_in), .prep(prep_r)
    );
    hdrtm_curve_prep #(.FRAC_BITS(FRAC_BITS)) u_prep_g (
        .clk(clk), .en(en), .curve_mode(mode_reg), .exposure_gain(gain_reg),
        .chan(green_in), .prep(prep_g)
    );
    hdrtm_curve_prep #(.FRAC_BITS(FRAC_BITS)) u_prep_b (
        .clk(clk), .en(en), .curve_mode(mode_reg), .exposure_gain(gain_reg),
        .chan(blue_in), .prep(prep_b)
    );

    hdrtm_divider u_div_r (.clk(clk), .en(en), .prep(prep_r), .result(red_out));
    hdrtm_divider u_div_g (.clk(clk), .en(en), .prep(prep_g), .result(green_out));
    hdrtm_divider u_div_b (.clk(clk), .en(en), .prep(prep_b), .result(blue_out));

    assign out_valid = vld_reg[PIPE_DEPTH-1];
    assign alpha_out = side_reg[PIPE_DEPTH-1].alpha;
    assign last_out  = side_reg[PIPE_DEPTH-1].last;

endmodule

// File: rtl/hdrtm_curve_prep.sv
`timescale 1ns / 1ps
// hdrtm_curve_prep: exposure scaling and curve numerator/denominator for one channel.
// Four register stages; depends on hdrtm_pkg.
module hdrtm_curve_prep #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     clk,
    input  logic                     en,
    input  hdrtm_pkg::curve_mode_t   curve_mode,
    input  logic [23:0]              exposure_gain,
    input  logic [23:0]              chan,
    output hdrtm_pkg::prep_word_t    prep
);
    import hdrtm_pkg::*;

    localparam logic [39:0] S1 = 40'd65536;

    logic [47:0] prod_reg;
    logic        byp_reg;
    logic [15:0] bval_reg;
    logic [20:0] an_reg, ad_reg;
    logic [32:0] ln_reg, ld_reg;
    logic        byp2_reg;
    logic [15:0] bval2_reg;
    logic [53:0] pn_reg;
    logic [54:0] pd_reg;
    prep_word_t  prep_reg;

    logic [47:0] e_full;
    logic [23:0] e_sat;
    logic [39:0] vx;
    logic        byp_next;
    logic [15:0] bval_next;
    logic [20:0] an_next, ad_next;
    logic [32:0] ln_next, ld_next;
    logic [54:0] k_next;
    logic [63:0] num_full, den_full;

    // stage B: saturate, align to Q16, build the linear factors
    always_comb
    begin
        e_full    = prod_reg >> FRAC_BITS;
        e_sat     = (e_full > 48'(CH_MAX)) ? CH_MAX : e_full[23:0];
        vx        = {e_sat, 16'b0} >> FRAC_BITS;
        byp_next  = 1'b0;
        bval_next = OUT_MAX;
        an_next   = '0;
        ad_next   = '0;
        ln_next   = '0;
        ld_next   = '0;
        case (curve_mode)
            CURVE_CLAMP:
            begin
                byp_next  = 1'b1;
                bval_next = (vx >= S1) ? OUT_MAX : vx[15:0];
            end
            CURVE_REINHARD:
            begin
                an_next = 21'd1;
                ad_next = 21'd1;
                ln_next = vx[32:0];
                ld_next = 33'(vx + S1);
            end
            CURVE_EXT_REINHARD:
            begin
                byp_next = (vx >= 40'd4 * S1);
                an_next  = vx[20:0];
                ln_next  = 33'(vx + 40'd16 * S1);
                ad_next  = 21'(40'd16 * S1);
                ld_next  = 33'(vx + S1);
            end
            CURVE_ACES:
            begin
                byp_next = (vx >= 40'd8 * S1);
                an_next  = vx[20:0];
                ad_next  = vx[20:0];
                ln_next  = 33'(40'd251 * vx + 40'd3 * S1);
                ld_next  = 33'(40'd243 * vx + 40'd59 * S1);
            end
            CURVE_UNCHARTED2:
            begin
                byp_next = (40'd5 * vx >= 40'd56 * S1);
                an_next  = vx[20:0];
                ad_next  = vx[20:0];
                ln_next  = 33'(40'd210 * vx + 40'd25 * S1);
                ld_next  = 33'(40'd15 * vx + 40'd50 * S1);
            end
            default:
            begin
                byp_next = 1'b1;
            end
        endcase
    end

    // constant term of the denominator, in units of s^2
    always_comb
    begin
        case (curve_mode)
            CURVE_ACES:       k_next = 55'd14 << 32;
            CURVE_UNCHARTED2: k_next = 55'd6 << 32;
            default:          k_next = '0;
        endcase
    end

    always_comb
    begin
        if (curve_mode == CURVE_UNCHARTED2)
        begin
            num_full = 64'(pn_reg) * 64'(UC_NUM_K);
            den_full = 64'(pd_reg) * 64'(UC_DEN_K);
        end
        else
        begin
            num_full = 64'(pn_reg);
            den_full = 64'(pd_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= 48'(chan) * 48'(exposure_gain);
            byp_reg   <= byp_next;
            bval_reg  <= bval_next;
            an_reg    <= an_next;
            ad_reg    <= ad_next;
            ln_reg    <= ln_next;
            ld_reg    <= ld_next;
            byp2_reg  <= byp_reg;
            bval2_reg <= bval_reg;
            pn_reg    <= 54'(an_reg) * 54'(ln_reg);
            pd_reg    <= 55'(ad_reg) * 55'(ld_reg) + k_next;
            prep_reg.bypass <= byp2_reg;
            prep_reg.bval   <= bval2_reg;
            prep_reg.num    <= num_full[DIV_W-1:0];
            prep_reg.den    <= den_full[DIV_W-1:0];
        end
    end

    assign prep = prep_reg;

endmodule

// File: rtl/hdrtm_divider.sv
`timescale 1ns / 1ps
// hdrtm_divider: pipelined restoring divider, floor(num*65536/den) saturated.
// One compare stage plus one stage per quotient bit; depends on hdrtm_pkg.
module hdrtm_divider (
    input  logic                  clk,
    input  logic                  en,
    input  hdrtm_pkg::prep_word_t prep,
    output logic [15:0]           result
);
    import hdrtm_pkg::*;

    div_word_t stg_reg [0:DIV_STEPS];

    // front: ratio at or above one saturates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stg_reg[0].bypass <= prep.bypass | (prep.num >= prep.den);
            stg_reg[0].q      <= prep.bypass ? prep.bval : OUT_MAX;
            stg_reg[0].rem    <= prep.num;
            stg_reg[0].den    <= prep.den;
        end
    end

    for (genvar i = 1; i <= DIV_STEPS; i++)
    begin : g_step
        logic [DIV_W:0]   rem2;
        logic             ge;
        logic [DIV_W:0]   diff;
        div_word_t        nxt;

        always_comb
        begin
            rem2 = {stg_reg[i-1].rem, 1'b0};
            ge   = (rem2 >= {1'b0, stg_reg[i-1].den});
            diff = rem2 - {1'b0, stg_reg[i-1].den};
            nxt  = stg_reg[i-1];
            if (!stg_reg[i-1].bypass)
            begin
                nxt.rem = ge ? diff[DIV_W-1:0] : rem2[DIV_W-1:0];
                nxt.q   = {stg_reg[i-1].q[OUT_W-2:0], ge};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stg_reg[i] <= nxt;
            end
        end
    end

    assign result = stg_reg[DIV_STEPS].q;

endmodule

// File: rtl/hdrtm_checker.sv
`timescale 1ns / 1ps
// hdrtm_checker: port-level assertions for hdr_tone_mapper_unit.
// Bound to the top level below; depends on nothing else.
module hdrtm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] red_out,
    input logic [15:0] green_out,
    input logic [15:0] blue_out,
    input logic [15:0] alpha_out,
    input logic        last_out
);

    // a held word keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_out) &&
        $stable(green_out) && $stable(blue_out) && $stable(alpha_out) &&
        $stable(last_out))
        else $error("held output word changed");

    // empty output stage never blocks input
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a stalled output stalls the input
    a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken during output stall");

endmodule

bind hdr_tone_mapper_unit hdrtm_checker u_hdrtm_checker (.*);
